// ----- rtl/pf3_pkg.sv -----
// shared types, sizes and mode codes for the 3x3 pixel filter
package pf3_pkg;

  // frame geometry
  localparam int WIDTH  = 256;
  localparam int HEIGHT = 256;
  localparam int CW     = $clog2(WIDTH);
  localparam int RW     = $clog2(HEIGHT);

  typedef logic [7:0]    pix_t;
  typedef logic [CW-1:0] col_t;
  typedef logic [RW-1:0] row_t;

  // filter operation codes
  typedef enum logic [2:0] {
    MODE_BLUR    = 3'd0,
    MODE_HEDGE   = 3'd1,
    MODE_VEDGE   = 3'd2,
    MODE_EDGE    = 3'd3,
    MODE_SHARPEN = 3'd4,
    MODE_INVERT  = 3'd5
  } mode_t;

  // 3x3 neighbourhood, top row first
  typedef struct packed {
    pix_t tl; pix_t tc; pix_t tr;
    pix_t ml; pix_t mc; pix_t mr;
    pix_t bl; pix_t bc; pix_t br;
  } win_t;

  // one result item, laid out as on the output bus (row in the low bits)
  typedef struct packed {
    pix_t       pix;
    logic [7:0] col;
    logic [7:0] row;
  } res_t;

endpackage

// ----- rtl/pf3_linebuf.sv -----
// two row banks of the line store, read-first, with registered reads
module pf3_linebuf (
  input  logic           clk,
  input  logic           acc,      // item accepted: read both banks, write one
  input  pf3_pkg::col_t  col,
  input  logic           bank,     // row parity of the accepted item
  input  pf3_pkg::pix_t  wr_pix,
  output pf3_pkg::pix_t  top,      // pixel two rows above, same column
  output pf3_pkg::pix_t  mid       // pixel one row above, same column
);

  pf3_pkg::pix_t bank0_mem [pf3_pkg::WIDTH];
  pf3_pkg::pix_t bank1_mem [pf3_pkg::WIDTH];
  pf3_pkg::pix_t q0_r;
  pf3_pkg::pix_t q1_r;
  logic          sel_r;

  // registered reads, old data returned when the same entry is written
  always_ff @(posedge clk) begin
    if (acc) begin
      q0_r  <= bank0_mem[col];
      q1_r  <= bank1_mem[col];
      sel_r <= bank;
    end
  end

  // the arriving pixel replaces the entry of its own parity bank
  always_ff @(posedge clk) begin
    if (acc && !bank) begin
      bank0_mem[col] <= wr_pix;
    end
    if (acc && bank) begin
      bank1_mem[col] <= wr_pix;
    end
  end

  // same-parity bank holds row r-2, the other one row r-1
  assign top = sel_r ? q1_r : q0_r;
  assign mid = sel_r ? q0_r : q1_r;

endmodule

// ----- rtl/pf3_kernel.sv -----
// 3x3 filter arithmetic for all modes
module pf3_kernel (
  input  logic [2:0]     mode,
  input  pf3_pkg::win_t  win,
  output pf3_pkg::pix_t  res
);

  // clamp a signed value to 0..255
  function automatic pf3_pkg::pix_t clamp12(input logic signed [11:0] v);
    pf3_pkg::pix_t r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 12'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic signed [11:0] sx(input pf3_pkg::pix_t p);
    return $signed({4'b0000, p});
  endfunction

  logic [9:0]         blur_sum;
  logic signed [11:0] h_sum;
  logic signed [11:0] v_sum;
  pf3_pkg::pix_t      h_cl;
  pf3_pkg::pix_t      v_cl;
  logic [8:0]         edge_sum;
  logic signed [11:0] mid_row;
  logic signed [11:0] mid_half;
  logic signed [11:0] sharp_sum;

  // blur: every term floored on its own
  assign blur_sum = 10'(win.tl >> 4) + 10'(win.tc >> 3) + 10'(win.tr >> 4)
                  + 10'(win.ml >> 3) + 10'(win.mc >> 2) + 10'(win.mr >> 3)
                  + 10'(win.bl >> 4) + 10'(win.bc >> 3) + 10'(win.br >> 4);

  // sobel pair
  assign h_sum = (sx(win.bl) + (sx(win.bc) <<< 1) + sx(win.br))
               - (sx(win.tl) + (sx(win.tc) <<< 1) + sx(win.tr));
  assign v_sum = (sx(win.tr) + (sx(win.mr) <<< 1) + sx(win.br))
               - (sx(win.tl) + (sx(win.ml) <<< 1) + sx(win.bl));
  assign h_cl     = clamp12(h_sum);
  assign v_cl     = clamp12(v_sum);
  assign edge_sum = {1'b0, h_cl} + {1'b0, v_cl};

  // sharpen: middle row halved with truncation toward zero
  assign mid_row   = (sx(win.mc) <<< 2) + (sx(win.mc) <<< 1) - sx(win.ml) - sx(win.mr);
  assign mid_half  = (mid_row + $signed({11'd0, mid_row[11]})) >>> 1;
  assign sharp_sum = mid_half - sx(win.tc >> 1) - sx(win.bc >> 1);

  // mode select
  always_comb begin
    case (pf3_pkg::mode_t'(mode))
      pf3_pkg::MODE_BLUR:    res = (blur_sum > 10'd255) ? 8'd255 : blur_sum[7:0];
      pf3_pkg::MODE_HEDGE:   res = h_cl;
      pf3_pkg::MODE_VEDGE:   res = v_cl;
      pf3_pkg::MODE_EDGE:    res = edge_sum[8:1];
      pf3_pkg::MODE_SHARPEN: res = clamp12(sharp_sum);
      pf3_pkg::MODE_INVERT:  res = ~win.mc;
      default:               res = win.mc;
    endcase
  end

endmodule

// ----- rtl/pixel_filter_3x3.sv -----
// top level of the streaming 3x3 pixel filter
//
// Takes one 8-bit greyscale pixel per clock while in_tready is high, in raster
// order, and returns every position of the frame once, tagged with its row and
// column. An interior result leaves when the pixel at its lower right corner has
// arrived; border pixels leave as they arrive (inverted in invert mode). Rate is
// one item per clock while out_tready is high; an item with two results (last
// column from row 2 on, bottom row from column 2 on) holds the input while the
// second waits, as the output register delivers one result per clock. The first
// result of an item passes the line store read, registered with stage 1, then
// the filter into the output register. The line store needs no clearing pass
// after reset: an entry is always written by an earlier row before it is used.
module pixel_filter_3x3 (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,   // mode
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // pixel[7:0]
  input  logic        in_tuser,      // frame_start
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // out_row[7:0], out_col[15:8], out_pixel[23:16]
  output logic        out_tlast      // last
);

  logic [2:0]       mode_r;
  pf3_pkg::row_t    row_r, row_nxt;
  pf3_pkg::col_t    col_r, col_nxt;
  pf3_pkg::row_t    cur_row;
  pf3_pkg::col_t    cur_col;
  logic             in_fire;

  logic             s1_valid_r, s1_valid_nxt;
  pf3_pkg::row_t    s1_row_r;
  pf3_pkg::col_t    s1_col_r;
  pf3_pkg::pix_t    s1_pix_r;
  logic             s1_go;
  logic             s1_int;
  logic             s1_bor;

  pf3_pkg::pix_t    top;
  pf3_pkg::pix_t    mid;
  pf3_pkg::pix_t    win_r [6];
  pf3_pkg::win_t    win;
  pf3_pkg::pix_t    kern_pix;
  pf3_pkg::res_t    int_res;
  pf3_pkg::res_t    bor_res;

  logic [1:0]       s2_n_r, s2_n_nxt;
  pf3_pkg::res_t    s2_e0_r, s2_e0_nxt;
  pf3_pkg::res_t    s2_e1_r, s2_e1_nxt;
  logic             s2_can;
  logic             s2_load;
  logic             out_fire;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pf3_pkg::MODE_BLUR;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // position of the arriving item and the one after it
  assign in_fire = in_tvalid && in_tready;
  assign cur_row = in_tuser ? '0 : row_r;
  assign cur_col = in_tuser ? '0 : col_r;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_fire) begin
      if (cur_col == pf3_pkg::CW'(pf3_pkg::WIDTH - 1)) begin
        col_nxt = '0;
        row_nxt = (cur_row == pf3_pkg::RW'(pf3_pkg::HEIGHT - 1)) ? '0
                                                                 : cur_row + 1'b1;
      end else begin
        col_nxt = cur_col + 1'b1;
        row_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line store: read above rows, write the arriving pixel
  pf3_linebuf u_linebuf (
    .clk    (clk),
    .acc    (in_fire),
    .col    (cur_col),
    .bank   (cur_row[0]),
    .wr_pix (in_tdata),
    .top    (top),
    .mid    (mid)
  );

  // stage 1 holds the item while the line store read completes
  assign s1_int = (s1_row_r >= pf3_pkg::RW'(2)) && (s1_col_r >= pf3_pkg::CW'(2));
  assign s1_bor = (s1_row_r == '0) || (s1_row_r == pf3_pkg::RW'(pf3_pkg::HEIGHT - 1))
               || (s1_col_r == '0) || (s1_col_r == pf3_pkg::CW'(pf3_pkg::WIDTH - 1));
  assign s1_go     = s1_valid_r && (!(s1_int || s1_bor) || s2_can);
  assign in_tready = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row_r <= cur_row;
      s1_col_r <= cur_col;
      s1_pix_r <= in_tdata;
    end
  end

  // window of the two previous columns, shifted as each item leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  assign win = '{tl: win_r[0], tc: win_r[3], tr: top,
                 ml: win_r[1], mc: win_r[4], mr: mid,
                 bl: win_r[2], bc: win_r[5], br: s1_pix_r};

  pf3_kernel u_kernel (
    .mode (mode_r),
    .win  (win),
    .res  (kern_pix)
  );

  // candidate results of the item in stage 1
  assign int_res = '{pix: kern_pix,
                     col: 8'(s1_col_r - 1'b1),
                     row: 8'(s1_row_r - 1'b1)};
  assign bor_res = '{pix: (mode_r == pf3_pkg::MODE_INVERT) ? ~s1_pix_r : s1_pix_r,
                     col: 8'(s1_col_r),
                     row: 8'(s1_row_r)};

  // output queue of up to two results of one item
  assign out_fire = out_tvalid && out_tready;
  assign s2_can   = (s2_n_r == 2'd0) || ((s2_n_r == 2'd1) && out_tready);
  assign s2_load  = s1_go && (s1_int || s1_bor);

  always_comb begin
    s2_n_nxt  = s2_n_r;
    s2_e0_nxt = s2_e0_r;
    s2_e1_nxt = s2_e1_r;
    if (out_fire) begin
      s2_n_nxt  = s2_n_r - 1'b1;
      s2_e0_nxt = s2_e1_r;
    end
    if (s2_load) begin
      s2_e0_nxt = s1_int ? int_res : bor_res;
      s2_e1_nxt = bor_res;
      s2_n_nxt  = (s1_int && s1_bor) ? 2'd2 : 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_n_r <= 2'd0;
    end else begin
      s2_n_r <= s2_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_e0_r <= s2_e0_nxt;
    s2_e1_r <= s2_e1_nxt;
  end

  assign out_tvalid = (s2_n_r != 2'd0);
  assign out_tdata  = s2_e0_r;
  assign out_tlast  = (s2_n_r == 2'd1);

  // new results only land in an empty or emptying queue
  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |-> (s2_n_r == 2'd0 || (s2_n_r == 2'd1 && out_fire)))
    else $error("output queue overrun");

  // queue never holds more than one item's results
  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    s2_n_r != 2'd3)
    else $error("output queue count out of range");

  // a stalled stage 1 item keeps its pixel and column
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_pix_r) && $stable(s1_col_r)))
    else $error("stage 1 item lost while stalled");

  // a full queue that is not drained stays full
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_n_r == 2'd2 && !out_tready) |=> (s2_n_r == 2'd2))
    else $error("output queue dropped a result");

endmodule
